// ===== hdl/mips_subset_instruction_core_assert.svh =====
// assertion macros for the mips subset core
`ifndef MIPS_SUBSET_INSTRUCTION_CORE_ASSERT_SVH
`define MIPS_SUBSET_INSTRUCTION_CORE_ASSERT_SVH
// implication checked on every edge outside reset
`define MSC_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// implication checked in the cycle after the antecedent
`define MSC_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

// ===== hdl/msc_pkg.sv =====
// ----------------------------------------------------------------------------
// msc_pkg
// shared types and constants of the mips subset core
// ----------------------------------------------------------------------------
package msc_pkg;
    localparam int unsigned DataWordsDefault = 4096;
    localparam int unsigned RegCountDefault  = 32;
    localparam logic [31:0] GpReset     = 32'h1000_8000;
    localparam logic [31:0] DataBase    = 32'h1000_0000;
    localparam logic [31:0] StartReset  = 32'h0040_0000;
    localparam logic [31:0] StackReset  = 32'h1000_3ff0 + 32'h10;
    localparam logic [4:0]  RegGp = 5'd28;
    localparam logic [4:0]  RegSp = 5'd29;
    localparam logic [4:0]  RegRa = 5'd31;

    // decoded operation class handed from the front to the back
    typedef enum logic [4:0] {
        OP_NOP, OP_SLL, OP_SRA, OP_JR, OP_MFHI, OP_MFLO, OP_MULT, OP_DIV,
        OP_ADDU, OP_SUBU, OP_SLT, OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_ADDIU,
        OP_ANDI, OP_LUI, OP_LW, OP_SW, OP_NL, OP_PRINT, OP_READ, OP_HALT,
        OP_BAD
    } t_op;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0, ACT_NEWLINE = 2'd1, ACT_PRINT = 2'd2, ACT_READ = 2'd3
    } t_action;

    typedef struct packed {
        t_op         op;
        logic [31:0] instr;
        logic [31:0] cval;
    } t_dec;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MEM, ST_MUL, ST_DIV, ST_DIVFIX, ST_OUT
    } t_state;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        halted;
        logic [1:0]  action;
        logic [31:0] print_value;
        logic        bad;
    } t_res;

    localparam logic [5:0] OpcSpecial = 6'h00;
    localparam logic [5:0] OpcJ     = 6'h02;
    localparam logic [5:0] OpcJal   = 6'h03;
    localparam logic [5:0] OpcBeq   = 6'h04;
    localparam logic [5:0] OpcBne   = 6'h05;
    localparam logic [5:0] OpcAddiu = 6'h09;
    localparam logic [5:0] OpcAndi  = 6'h0c;
    localparam logic [5:0] OpcLui   = 6'h0f;
    localparam logic [5:0] OpcTrap  = 6'h1a;
    localparam logic [5:0] OpcLw    = 6'h23;
    localparam logic [5:0] OpcSw    = 6'h2b;
    localparam logic [5:0] FnSll  = 6'h00;
    localparam logic [5:0] FnSra  = 6'h03;
    localparam logic [5:0] FnJr   = 6'h08;
    localparam logic [5:0] FnMfhi = 6'h10;
    localparam logic [5:0] FnMflo = 6'h12;
    localparam logic [5:0] FnMult = 6'h18;
    localparam logic [5:0] FnDiv  = 6'h1a;
    localparam logic [5:0] FnAddu = 6'h21;
    localparam logic [5:0] FnSubu = 6'h23;
    localparam logic [5:0] FnSlt  = 6'h2a;
    localparam logic [3:0] TrNewline = 4'h0;
    localparam logic [3:0] TrPrint   = 4'h1;
    localparam logic [3:0] TrRead    = 4'h5;

    function automatic t_op decode(input logic [31:0] w);
        t_op o;
        o = OP_BAD;
        case (w[31:26])
            OpcSpecial: begin
                case (w[5:0])
                    FnSll:  o = OP_SLL;
                    FnSra:  o = OP_SRA;
                    FnJr:   o = OP_JR;
                    FnMfhi: o = OP_MFHI;
                    FnMflo: o = OP_MFLO;
                    FnMult: o = OP_MULT;
                    FnDiv:  o = OP_DIV;
                    FnAddu: o = OP_ADDU;
                    FnSubu: o = OP_SUBU;
                    FnSlt:  o = OP_SLT;
                    default: o = OP_BAD;
                endcase
            end
            OpcJ:     o = OP_J;
            OpcJal:   o = OP_JAL;
            OpcBeq:   o = OP_BEQ;
            OpcBne:   o = OP_BNE;
            OpcAddiu: o = OP_ADDIU;
            OpcAndi:  o = OP_ANDI;
            OpcLui:   o = OP_LUI;
            OpcLw:    o = OP_LW;
            OpcSw:    o = OP_SW;
            OpcTrap: begin
                case (w[3:0])
                    TrNewline: o = OP_NL;
                    TrPrint:   o = OP_PRINT;
                    TrRead:    o = OP_READ;
                    default:   o = OP_HALT;
                endcase
            end
            default: o = OP_BAD;
        endcase
        return o;
    endfunction
endpackage

// ===== hdl/mips_subset_instruction_core.sv =====
// ----------------------------------------------------------------------------
// mips_subset_instruction_core
// executes one mips subset instruction per input transfer
// ----------------------------------------------------------------------------
// s_axis: tdata[31:0] instruction word, tdata[63:32] console value.
// m_axis: one result transfer per instruction; tdata[31:0] next pc,
//   [32] halted, [34:33] console action, [66:35] print value, [67] bad opcode.
// apb: register 0 start address (also loads the pc), register 1 stack top
//   (also loads sp). write only while idle.
// a decode queue of two entries sits in front of the execute unit.
// lw passes through a memory state; mult forms 2 bits a step over 16 steps;
//   div forms one quotient bit a step, then a sign fix state.
// the execute unit takes one simple instruction per cycle while results are taken.
// reset clears the pc to the start address, registers to their reset values
// and empties the queue. when the result is not taken the execute unit holds
// and the queue fills, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module mips_subset_instruction_core import msc_pkg::*; #(
    parameter int unsigned DATA_WORDS = DataWordsDefault,
    parameter int unsigned REG_COUNT  = RegCountDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // instr_word, console_value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // next_pc, halted, console_action, print_value, bad_instruction
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    t_dec        w_dec;
    logic        w_dv, w_dr;
    t_res        w_res;
    logic        w_wr;
    logic [31:0] r_start, r_stack;

    assign pready = 1'b1;
    assign w_wr = psel && penable && pwrite;
    assign prdata = (paddr == 3'd0) ? r_start : (paddr == 3'd4) ? r_stack : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= StartReset; r_stack <= StackReset;
        end else if (w_wr) begin
            if (paddr == 3'd0) r_start <= pwdata;
            if (paddr == 3'd4) r_stack <= pwdata;
        end
    end

    msc_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_instr(s_axis_tdata[31:0]), .i_cval(s_axis_tdata[63:32]),
        .o_valid(w_dv), .i_ready(w_dr), .o_dec(w_dec)
    );

    msc_back #(.DATA_WORDS(DATA_WORDS), .REG_COUNT(REG_COUNT)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(w_dv), .o_ready(w_dr), .i_dec(w_dec),
        .i_cfg_pc_we(w_wr && paddr == 3'd0), .i_cfg_sp_we(w_wr && paddr == 3'd4),
        .i_cfg_data(pwdata),
        .o_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready), .o_res(w_res)
    );

    assign m_axis_tdata = {4'd0, w_res.bad, w_res.print_value, w_res.action,
                           w_res.halted, w_res.next_pc};
endmodule

// ===== hdl/msc_front.sv =====
// ----------------------------------------------------------------------------
// msc_front
// accepts instruction transfers, decodes them and queues them for the back
// ----------------------------------------------------------------------------
module msc_front import msc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_instr,
    input  logic [31:0] i_cval,
    output logic        o_valid,
    input  logic        i_ready,
    output t_dec        o_dec
);
    // two-entry queue
    t_dec        r_q [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_dec   = r_q[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp].op    <= decode(i_instr);
            r_q[r_wp].instr <= i_instr;
            r_q[r_wp].cval  <= i_cval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    `include "mips_subset_instruction_core_assert.svh"
    `MSC_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, r_cnt == 2'd2, !w_push)
    `MSC_ASSERT_NEXT(a_cnt_push, i_clk, i_rst_n, w_push && !w_pop, r_cnt == $past(r_cnt) + 2'd1)
    `MSC_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt != 2'd3)
endmodule

// ===== hdl/msc_back.sv =====
// ----------------------------------------------------------------------------
// msc_back
// executes decoded instructions: register file, hi/lo, data store, mul/div
// ----------------------------------------------------------------------------
module msc_back import msc_pkg::*; #(
    parameter int unsigned DATA_WORDS = DataWordsDefault,
    parameter int unsigned REG_COUNT  = RegCountDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_dec        i_dec,
    input  logic        i_cfg_pc_we,
    input  logic        i_cfg_sp_we,
    input  logic [31:0] i_cfg_data,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output t_res        o_res
);
    localparam int unsigned AW = $clog2(DATA_WORDS);

    logic [31:0] r_gpr [REG_COUNT];
    logic [31:0] r_mem [DATA_WORDS];
    logic [31:0] r_hi, r_lo, r_pc;
    logic        r_stop;
    t_state      r_state, n_state;
    t_dec        r_cur;
    logic [31:0] r_a, r_b, r_rdata;
    logic        r_mem_ok;
    // multiply: 16 steps of 32x2
    logic [63:0] r_acc;
    logic [4:0]  r_cnt;
    // divide: restoring, one bit a step on magnitudes
    logic [31:0] r_rem, r_quo, r_dvs;
    logic        r_qneg, r_rneg;
    t_res        r_res;
    logic        r_res_valid;

    logic [4:0]  w_rs, w_rt, w_rd, w_sh;
    logic [31:0] w_a, w_b, w_simm, w_pc4, w_addr, w_idx;
    logic        w_take, w_inrange;
    logic [31:0] w_npc, w_wval;
    logic        w_we;
    logic [4:0]  w_wr;
    logic [1:0]  w_act;
    logic [31:0] w_pval;
    logic        w_bad, w_halt;
    logic [33:0] w_pp;
    logic [32:0] w_dsub;
    logic [31:0] w_amag, w_bmag;
    logic        w_res_set;

    assign w_rs   = i_dec.instr[25:21];
    assign w_rt   = i_dec.instr[20:16];
    assign w_rd   = i_dec.instr[15:11];
    assign w_sh   = i_dec.instr[10:6];
    assign w_a    = r_gpr[w_rs];
    assign w_b    = r_gpr[w_rt];
    assign w_simm = {{16{i_dec.instr[15]}}, i_dec.instr[15:0]};
    assign w_pc4  = r_pc + 32'd4;
    assign w_addr = w_a + w_simm;
    assign w_idx  = (w_addr - DataBase) >> 2;
    assign w_inrange = (w_idx < 32'(DATA_WORDS));
    assign w_amag = w_a[31] ? -w_a : w_a;
    assign w_bmag = w_b[31] ? -w_b : w_b;

    assign o_ready = (r_state == ST_IDLE) && !(r_res_valid && !i_res_ready);
    assign w_take  = i_valid && o_ready;
    assign o_res_valid = r_res_valid;
    assign o_res = r_res;

    // results of the simple ops, computed combinationally
    always_comb begin
        w_npc = w_pc4; w_we = 1'b0; w_wr = w_rd; w_wval = '0;
        w_act = ACT_NONE; w_pval = '0; w_bad = 1'b0; w_halt = 1'b0;
        case (i_dec.op)
            OP_SLL:  begin w_we = 1'b1; w_wval = w_b << w_sh; end
            OP_SRA:  begin w_we = 1'b1; w_wval = 32'($signed(w_b) >>> w_sh); end
            OP_JR:   w_npc = w_a;
            OP_MFHI: begin w_we = 1'b1; w_wval = r_hi; end
            OP_MFLO: begin w_we = 1'b1; w_wval = r_lo; end
            OP_ADDU: begin w_we = 1'b1; w_wval = w_a + w_b; end
            OP_SUBU: begin w_we = 1'b1; w_wval = w_a - w_b; end
            OP_SLT:  begin
                w_we = 1'b1; w_wval = {31'd0, $signed(w_a) < $signed(w_b)};
            end
            OP_J:    w_npc = {w_pc4[31:28], i_dec.instr[25:0], 2'b00};
            OP_JAL:  begin
                w_npc = {w_pc4[31:28], i_dec.instr[25:0], 2'b00};
                w_we = 1'b1; w_wr = RegRa; w_wval = w_pc4;
            end
            OP_BEQ:  if (w_a == w_b) w_npc = w_pc4 + (w_simm << 2);
            OP_BNE:  if (w_a != w_b) w_npc = w_pc4 + (w_simm << 2);
            OP_ADDIU: begin w_we = 1'b1; w_wr = w_rt; w_wval = w_a + w_simm; end
            OP_ANDI: begin
                w_we = 1'b1; w_wr = w_rt; w_wval = w_a & {16'd0, i_dec.instr[15:0]};
            end
            OP_LUI:  begin w_we = 1'b1; w_wr = w_rt; w_wval = {i_dec.instr[15:0], 16'd0}; end
            OP_NL:   w_act = ACT_NEWLINE;
            OP_PRINT: begin w_act = ACT_PRINT; w_pval = w_a; end
            OP_READ: begin w_act = ACT_READ; w_we = 1'b1; w_wr = w_rt; w_wval = i_dec.cval; end
            OP_HALT: w_halt = 1'b1;
            OP_BAD:  w_bad = 1'b1;
            default: w_npc = w_pc4;
        endcase
    end

    // partial product of r_b and two multiplier bits
    assign w_pp   = (r_a[0] ? {2'b00, r_b} : 34'd0) + (r_a[1] ? {1'b0, r_b, 1'b0} : 34'd0);
    assign w_dsub = {r_rem[31:0], r_quo[31]} - {1'b0, r_dvs};

    always_comb begin
        n_state = r_state;
        w_res_set = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_take) begin
                    w_res_set = r_stop || (i_dec.op != OP_LW && i_dec.op != OP_MULT
                                           && i_dec.op != OP_DIV);
                end
                if (w_take && !r_stop) begin
                    case (i_dec.op)
                        OP_LW:   n_state = ST_MEM;
                        OP_MULT: n_state = ST_MUL;
                        OP_DIV:  n_state = ST_DIV;
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_MEM: begin
                n_state = ST_IDLE;
                w_res_set = 1'b1;
            end
            ST_MUL: begin
                if (r_cnt == 5'd15) begin
                    n_state = ST_IDLE;
                    w_res_set = 1'b1;
                end
            end
            ST_DIV:    if (r_cnt == 5'd31) n_state = ST_DIVFIX;
            ST_DIVFIX: begin
                n_state = ST_IDLE;
                w_res_set = 1'b1;
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_take && !r_stop && i_dec.op == OP_SW && w_inrange)
            r_mem[w_idx[AW-1:0]] <= w_b;
        r_rdata <= r_mem[w_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_res_valid <= 1'b0; r_stop <= 1'b0;
            r_pc <= StartReset; r_hi <= '0; r_lo <= '0; r_cnt <= '0;
            for (int i = 0; i < REG_COUNT; i++) begin
                if (i == int'(RegGp)) r_gpr[i] <= GpReset;
                else if (i == int'(RegSp)) r_gpr[i] <= StackReset;
                else r_gpr[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_res_valid <= w_res_set || (r_res_valid && !i_res_ready);
            if (i_cfg_pc_we) r_pc <= i_cfg_data;
            if (i_cfg_sp_we) r_gpr[RegSp] <= i_cfg_data;
            case (r_state)
                ST_IDLE: begin
                    if (w_take) begin
                        r_cur <= i_dec;
                        if (r_stop) begin
                            r_res <= '{next_pc: r_pc, halted: 1'b1, action: ACT_NONE,
                                       print_value: '0, bad: 1'b0};
                        end else begin
                            r_pc <= w_npc;
                            r_mem_ok <= w_inrange;
                            r_a <= w_a; r_b <= w_b; r_cnt <= '0;
                            r_acc <= '0;
                            r_rem <= '0; r_quo <= w_amag; r_dvs <= w_bmag;
                            r_qneg <= w_a[31] ^ w_b[31]; r_rneg <= w_a[31];
                            if (w_we && w_wr != 5'd0) r_gpr[w_wr] <= w_wval;
                            if (w_halt) r_stop <= 1'b1;
                            r_res <= '{next_pc: w_npc, halted: w_halt, action: w_act,
                                       print_value: w_pval, bad: w_bad};
                        end
                    end
                end
                ST_MEM: begin
                    if (r_cur.instr[20:16] != 5'd0)
                        r_gpr[r_cur.instr[20:16]] <= r_mem_ok ? r_rdata : '0;
                end
                ST_MUL: begin
                    // unsigned product of operands, 2 bits per step, corrected for sign
                    r_acc <= r_acc + ({30'd0, w_pp} << {r_cnt, 1'b0});
                    r_a <= r_a >> 2;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd15) begin
                        r_hi <= 32'((r_acc + ({30'd0, w_pp} << {r_cnt, 1'b0})) >> 32)
                              - (r_gpr[r_cur.instr[25:21]][31] ? r_gpr[r_cur.instr[20:16]] : 32'd0)
                              - (r_gpr[r_cur.instr[20:16]][31] ? r_gpr[r_cur.instr[25:21]] : 32'd0);
                        r_lo <= 32'(r_acc + ({30'd0, w_pp} << {r_cnt, 1'b0}));
                    end
                end
                ST_DIV: begin
                    if (!w_dsub[32]) r_rem <= w_dsub[31:0];
                    else r_rem <= {r_rem[30:0], r_quo[31]};
                    r_quo <= {r_quo[30:0], !w_dsub[32]};
                    r_cnt <= r_cnt + 5'd1;
                end
                ST_DIVFIX: begin
                    if (r_dvs == 32'd0) begin
                        r_lo <= 32'hffff_ffff; r_hi <= r_gpr[r_cur.instr[25:21]];
                    end else begin
                        r_lo <= r_qneg ? -r_quo : r_quo;
                        r_hi <= r_rneg ? -r_rem : r_rem;
                    end
                end
                default: ;
            endcase
        end
    end

    `include "mips_subset_instruction_core_assert.svh"
    `MSC_ASSERT_IMP(a_busy_not_ready, i_clk, i_rst_n, r_state != ST_IDLE, !o_ready)
    `MSC_ASSERT_IMP(a_zero_reg, i_clk, i_rst_n, 1'b1, r_gpr[0] == 32'd0)
    `MSC_ASSERT_NEXT(a_stop_sticky, i_clk, i_rst_n, r_stop, r_stop)
endmodule
